/* src/cluster_chain_table_defines.svh */
// Assertion macros for the cluster chain table.
// Used by the top level; the macros expect signals named clk and arst_n in scope.
`ifndef CLUSTER_CHAIN_TABLE_DEFINES_SVH
`define CLUSTER_CHAIN_TABLE_DEFINES_SVH

// Condition that must hold at every clock edge out of reset
`define CCHT_ASSERT_NOW(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// Same-cycle implication
`define CCHT_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication
`define CCHT_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* src/ccht_pkg.sv */
// Shared types and constants of the cluster chain table.
// No dependencies; used by the controller, the datapath and the top level.
`default_nettype none

package ccht_pkg;

	// field widths
	localparam int MODE_W  = 3;
	localparam int CL_W    = 10;
	localparam int STAT_W  = 2;
	localparam int FC_W    = 11;
	localparam int FB_W    = 26;
	localparam int ACT_W   = 11;
	localparam int BYTES_W = 16;
	localparam int PROD_W  = FC_W + BYTES_W;
	localparam int IN_W    = 16;
	localparam int OUT_W   = 56;
	localparam int CFG_IDX_W = 1;

	// operation codes
	localparam logic [MODE_W-1:0] MODE_CLEAR  = 3'd0;
	localparam logic [MODE_W-1:0] MODE_ALLOC  = 3'd1;
	localparam logic [MODE_W-1:0] MODE_EXTEND = 3'd2;
	localparam logic [MODE_W-1:0] MODE_FOLLOW = 3'd3;
	localparam logic [MODE_W-1:0] MODE_FREE   = 3'd4;
	localparam logic [MODE_W-1:0] MODE_COUNT  = 3'd5;

	// result status codes
	localparam logic [STAT_W-1:0] ST_OK   = 2'd0;
	localparam logic [STAT_W-1:0] ST_FULL = 2'd1;
	localparam logic [STAT_W-1:0] ST_OPEN = 2'd2;
	localparam logic [STAT_W-1:0] ST_BAD  = 2'd3;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_ACTIVE = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BYTES  = 1'd1;

	// controller to datapath commands
	typedef struct packed {
		logic              load_req;   // capture the accepted request
		logic              scan_start; // pointer, pending read and count to zero
		logic              scan_step;  // issue next scan read
		logic              count_en;   // count free entries seen by the scan
		logic              sweep_step; // write FREE at pointer, advance
		logic              rd_cluster; // read entry of the request cluster
		logic              walk_free;  // write FREE at current chain entry
		logic              walk_adv;   // read next chain entry
		logic              mark_end;   // mark found entry END
		logic              link_wr;    // link current entry to found entry
		logic              mul;        // free count times cluster bytes
		logic              res_end;
		logic              res_link;
		logic              res_count;
		logic              set_status;
		logic [STAT_W-1:0] status;
		logic              emit;       // move result to output register
	} cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic [MODE_W-1:0] mode;
		logic              file_open;
		logic              c_oor;       // request cluster beyond active count
		logic              rd_free;
		logic              rd_end;
		logic              rd_next_oor; // read link beyond active count
		logic              rd_self;     // read link points at itself
		logic              scan_hit;
		logic              scan_idle;
		logic              sweep_last;
		logic              out_room;
	} stat_t;

endpackage

`default_nettype wire

/* src/ccht_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module ccht_ram #(
	parameter int WIDTH = 11,
	parameter int DEPTH = 1024
) (
	input  wire                     clk,
	input  wire                     we,
	input  wire [$clog2(DEPTH)-1:0] waddr,
	input  wire [WIDTH-1:0]         wdata,
	input  wire                     re,
	input  wire [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]        rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read, old data on collision
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

/* src/ccht_ctrl.sv */
// Controller state machine of the cluster chain table.
// Depends on ccht_pkg; drives ccht_dp through cmd_t and reads stat_t.
`default_nettype none

module ccht_ctrl (
	input  wire             clk,
	input  wire             arst_n,
	input  wire             in_valid,
	output logic            in_ready,
	input  wire ccht_pkg::stat_t stat,
	output ccht_pkg::cmd_t  cmd
);

	localparam logic [3:0] S_BOOT = 4'd0;
	localparam logic [3:0] S_IDLE = 4'd1;
	localparam logic [3:0] S_DISP = 4'd2;
	localparam logic [3:0] S_CLR  = 4'd3;
	localparam logic [3:0] S_LOOK = 4'd4;
	localparam logic [3:0] S_SCAN = 4'd5;
	localparam logic [3:0] S_LINK = 4'd6;
	localparam logic [3:0] S_WALK = 4'd7;
	localparam logic [3:0] S_CNT  = 4'd8;
	localparam logic [3:0] S_MUL  = 4'd9;
	localparam logic [3:0] S_EMIT = 4'd10;

	logic [3:0] state_q;
	logic [3:0] state_nxt;

	assign in_ready = (state_q == S_IDLE);

	// next state and commands
	always_comb begin
		state_nxt = state_q;
		cmd       = '0;
		case (state_q)
			S_BOOT: begin
				cmd.sweep_step = 1'b1;
				if (stat.sweep_last) begin
					state_nxt = S_IDLE;
				end
			end
			S_IDLE: begin
				if (in_valid) begin
					cmd.load_req = 1'b1;
					state_nxt    = S_DISP;
				end
			end
			S_DISP: begin
				case (stat.mode)
					ccht_pkg::MODE_CLEAR: begin
						cmd.scan_start = 1'b1;
						state_nxt      = S_CLR;
					end
					ccht_pkg::MODE_ALLOC: begin
						cmd.scan_start = 1'b1;
						state_nxt      = S_SCAN;
					end
					ccht_pkg::MODE_EXTEND, ccht_pkg::MODE_FOLLOW: begin
						if (stat.c_oor) begin
							cmd.set_status = 1'b1;
							cmd.status     = ccht_pkg::ST_BAD;
							state_nxt      = S_EMIT;
						end else begin
							cmd.rd_cluster = 1'b1;
							state_nxt      = S_LOOK;
						end
					end
					ccht_pkg::MODE_FREE: begin
						if (stat.file_open) begin
							cmd.set_status = 1'b1;
							cmd.status     = ccht_pkg::ST_OPEN;
							state_nxt      = S_EMIT;
						end else if (stat.c_oor) begin
							cmd.set_status = 1'b1;
							cmd.status     = ccht_pkg::ST_BAD;
							state_nxt      = S_EMIT;
						end else begin
							cmd.rd_cluster = 1'b1;
							state_nxt      = S_WALK;
						end
					end
					ccht_pkg::MODE_COUNT: begin
						cmd.scan_start = 1'b1;
						cmd.res_count  = 1'b1;
						state_nxt      = S_CNT;
					end
					default: begin
						state_nxt = S_EMIT;
					end
				endcase
			end
			S_CLR: begin
				cmd.sweep_step = 1'b1;
				if (stat.sweep_last) begin
					state_nxt = S_EMIT;
				end
			end
			// entry of the request cluster is in the read register
			S_LOOK: begin
				if (stat.rd_free) begin
					cmd.set_status = 1'b1;
					cmd.status     = ccht_pkg::ST_BAD;
					state_nxt      = S_EMIT;
				end else if (stat.rd_end) begin
					if (stat.mode == ccht_pkg::MODE_FOLLOW) begin
						cmd.res_end = 1'b1;
						state_nxt   = S_EMIT;
					end else begin
						cmd.scan_start = 1'b1;
						state_nxt      = S_SCAN;
					end
				end else begin
					cmd.res_link = 1'b1;
					state_nxt    = S_EMIT;
				end
			end
			// lowest free entry search
			S_SCAN: begin
				if (stat.scan_hit) begin
					cmd.mark_end = 1'b1;
					state_nxt    = (stat.mode == ccht_pkg::MODE_EXTEND) ? S_LINK : S_EMIT;
				end else if (stat.scan_idle) begin
					cmd.set_status = 1'b1;
					cmd.status     = ccht_pkg::ST_FULL;
					state_nxt      = S_EMIT;
				end else begin
					cmd.scan_step = 1'b1;
				end
			end
			S_LINK: begin
				cmd.link_wr = 1'b1;
				state_nxt   = S_EMIT;
			end
			// chain walk, one link a cycle
			S_WALK: begin
				if (stat.rd_free) begin
					state_nxt = S_EMIT;
				end else begin
					cmd.walk_free = 1'b1;
					if (stat.rd_end || stat.rd_next_oor || stat.rd_self) begin
						state_nxt = S_EMIT;
					end else begin
						cmd.walk_adv = 1'b1;
					end
				end
			end
			S_CNT: begin
				cmd.scan_step = 1'b1;
				cmd.count_en  = 1'b1;
				if (stat.scan_idle) begin
					state_nxt = S_MUL;
				end
			end
			S_MUL: begin
				cmd.mul   = 1'b1;
				state_nxt = S_EMIT;
			end
			S_EMIT: begin
				if (stat.out_room) begin
					cmd.emit  = 1'b1;
					state_nxt = S_IDLE;
				end
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_BOOT;
		end else begin
			state_q <= state_nxt;
		end
	end

endmodule

`default_nettype wire

/* src/ccht_dp.sv */
// Datapath of the cluster chain table: config registers, link RAM, scan and
// walk pointers, free counter, multiplier and output register.
// Depends on ccht_pkg and ccht_ram; commanded by ccht_ctrl.
`default_nettype none

module ccht_dp #(
	parameter int NUM_CLUSTERS = 1024
) (
	input  wire                                clk,
	input  wire                                arst_n,
	// configuration writes
	input  wire                                cfg_we,
	input  wire [ccht_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire [ccht_pkg::BYTES_W-1:0]        cfg_wdata,
	// request fields
	input  wire [ccht_pkg::MODE_W-1:0]         in_mode,
	input  wire [ccht_pkg::CL_W-1:0]           in_cluster,
	input  wire                                in_file_open,
	// result register
	input  wire                                out_ready,
	output logic                               out_valid,
	output logic [ccht_pkg::STAT_W-1:0]        out_status,
	output logic [ccht_pkg::CL_W-1:0]          out_cluster,
	output logic                               out_chain_end,
	output logic [ccht_pkg::FC_W-1:0]          out_free_clusters,
	output logic [ccht_pkg::FB_W-1:0]          out_free_bytes,
	// controller link
	input  wire ccht_pkg::cmd_t                cmd,
	output ccht_pkg::stat_t                    stat
);

	localparam int AW   = $clog2(NUM_CLUSTERS);
	localparam int LW   = $clog2(2 * NUM_CLUSTERS);
	localparam int CNTW = $clog2(NUM_CLUSTERS + 1);
	localparam logic [LW-1:0] LINK_FREE = LW'(2 * NUM_CLUSTERS - 1);
	localparam logic [LW-1:0] LINK_END  = LW'(2 * NUM_CLUSTERS - 2);

	logic [ccht_pkg::ACT_W-1:0]   active_q;
	logic [ccht_pkg::BYTES_W-1:0] bytes_q;
	logic [ccht_pkg::MODE_W-1:0]  mode_q;
	logic [ccht_pkg::CL_W-1:0]    clus_q;
	logic                         open_q;
	logic [CNTW-1:0]              ptr_q;
	logic                         pend_q;
	logic [AW-1:0]                rd_addr_q;
	logic [AW-1:0]                cur_q;
	logic [ccht_pkg::FC_W-1:0]    cnt_q;
	logic [ccht_pkg::PROD_W-1:0]  prod_s1;
	logic [ccht_pkg::STAT_W-1:0]  w_status_q;
	logic [ccht_pkg::CL_W-1:0]    w_cl_q;
	logic                         w_end_q;
	logic                         w_count_q;
	logic                         o_valid_q;

	logic [CNTW-1:0] n_act;
	logic            scan_issue;
	logic            ram_we;
	logic [AW-1:0]   ram_waddr;
	logic [LW-1:0]   ram_wdata;
	logic            ram_re;
	logic [AW-1:0]   ram_raddr;
	logic [LW-1:0]   ram_rdata;

	// effective active count, at most the table depth
	assign n_act = (32'(active_q) >= 32'(NUM_CLUSTERS)) ? CNTW'(NUM_CLUSTERS)
	                                                     : CNTW'(active_q);
	assign scan_issue = cmd.scan_step && (ptr_q < n_act);

	// status toward the controller
	always_comb begin
		stat.mode        = mode_q;
		stat.file_open   = open_q;
		stat.c_oor       = 32'(clus_q) >= 32'(n_act);
		stat.rd_free     = ram_rdata == LINK_FREE;
		stat.rd_end      = ram_rdata == LINK_END;
		stat.rd_next_oor = 32'(ram_rdata) >= 32'(n_act);
		stat.rd_self     = ram_rdata == LW'(cur_q);
		stat.scan_hit    = pend_q && (ram_rdata == LINK_FREE);
		stat.scan_idle   = !pend_q && (ptr_q >= n_act);
		stat.sweep_last  = ptr_q == CNTW'(NUM_CLUSTERS - 1);
		stat.out_room    = !o_valid_q || out_ready;
	end

	// RAM write port select
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = cur_q;
		ram_wdata = LINK_FREE;
		if (cmd.sweep_step) begin
			ram_we    = 1'b1;
			ram_waddr = ptr_q[AW-1:0];
		end else if (cmd.walk_free) begin
			ram_we    = 1'b1;
		end else if (cmd.mark_end) begin
			ram_we    = 1'b1;
			ram_waddr = rd_addr_q;
			ram_wdata = LINK_END;
		end else if (cmd.link_wr) begin
			ram_we    = 1'b1;
			ram_wdata = LW'(rd_addr_q);
		end
	end

	// RAM read port select
	always_comb begin
		ram_re    = 1'b0;
		ram_raddr = ptr_q[AW-1:0];
		if (scan_issue) begin
			ram_re    = 1'b1;
		end else if (cmd.rd_cluster) begin
			ram_re    = 1'b1;
			ram_raddr = AW'(clus_q);
		end else if (cmd.walk_adv) begin
			ram_re    = 1'b1;
			ram_raddr = ram_rdata[AW-1:0];
		end
	end

	ccht_ram #(
		.WIDTH (LW),
		.DEPTH (NUM_CLUSTERS)
	) u_link_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 11'd1024;
			bytes_q  <= 16'd512;
		end else if (cfg_we) begin
			if (cfg_index == ccht_pkg::REG_ACTIVE) begin
				active_q <= cfg_wdata[ccht_pkg::ACT_W-1:0];
			end
			if (cfg_index == ccht_pkg::REG_BYTES) begin
				bytes_q <= cfg_wdata;
			end
		end
	end

	// scan pointer and pending read flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q  <= '0;
			pend_q <= 1'b0;
		end else begin
			if (cmd.scan_start) begin
				ptr_q  <= '0;
				pend_q <= 1'b0;
			end else if (cmd.sweep_step || scan_issue) begin
				ptr_q <= ptr_q + 1'b1;
			end
			if (cmd.scan_step) begin
				pend_q <= scan_issue;
			end
		end
	end

	// request, walk and scan payload
	always_ff @(posedge clk) begin
		if (cmd.load_req) begin
			mode_q <= in_mode;
			clus_q <= in_cluster;
			open_q <= in_file_open;
		end
		if (scan_issue) begin
			rd_addr_q <= ptr_q[AW-1:0];
		end
		if (cmd.rd_cluster) begin
			cur_q <= AW'(clus_q);
		end else if (cmd.walk_adv) begin
			cur_q <= ram_rdata[AW-1:0];
		end else if (cmd.mark_end && !(mode_q == ccht_pkg::MODE_EXTEND)) begin
			cur_q <= cur_q;
		end
		if (cmd.scan_start) begin
			cnt_q <= '0;
		end else if (cmd.count_en && pend_q && (ram_rdata == LINK_FREE)) begin
			cnt_q <= cnt_q + 1'b1;
		end
		if (cmd.mul) begin
			prod_s1 <= ccht_pkg::PROD_W'(cnt_q) * ccht_pkg::PROD_W'(bytes_q);
		end
	end

	// working result
	always_ff @(posedge clk) begin
		if (cmd.load_req) begin
			w_status_q <= ccht_pkg::ST_OK;
			w_cl_q     <= '0;
			w_end_q    <= 1'b0;
			w_count_q  <= 1'b0;
		end else begin
			if (cmd.set_status) begin
				w_status_q <= cmd.status;
			end
			if (cmd.mark_end) begin
				w_cl_q <= ccht_pkg::CL_W'(rd_addr_q);
			end else if (cmd.res_link) begin
				w_cl_q <= ccht_pkg::CL_W'(ram_rdata);
			end
			if (cmd.res_end) begin
				w_end_q <= 1'b1;
			end
			if (cmd.res_count) begin
				w_count_q <= 1'b1;
			end
		end
	end

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			o_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			o_valid_q <= 1'b1;
		end else if (out_ready) begin
			o_valid_q <= 1'b0;
		end
	end

	// output register payload, free bytes saturate
	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_status        <= w_status_q;
			out_cluster       <= w_cl_q;
			out_chain_end     <= w_end_q;
			out_free_clusters <= w_count_q ? cnt_q : '0;
			if (!w_count_q) begin
				out_free_bytes <= '0;
			end else if (prod_s1[ccht_pkg::PROD_W-1:ccht_pkg::FB_W] != '0) begin
				out_free_bytes <= '1;
			end else begin
				out_free_bytes <= prod_s1[ccht_pkg::FB_W-1:0];
			end
		end
	end

	assign out_valid = o_valid_q;

endmodule

`default_nettype wire

/* src/cluster_chain_table.sv */
// Cluster chain table: FAT-style allocation table manager, top level.
// Depends on ccht_pkg, ccht_ctrl, ccht_dp (with ccht_ram) and the defines header.
//
// One request at a time, one result per request. The link table lives in a
// RAM with one write and one registered read port; every scan or walk goes
// through that read port one entry per cycle. A result waits for room in the
// output register. After reset the table is swept to FREE before the first
// request is taken; configuration writes are taken at any time. A new request
// is accepted while the previous result still waits in the output register.
`default_nettype none

`include "cluster_chain_table_defines.svh"

module cluster_chain_table #(
	parameter int NUM_CLUSTERS = 1024
) (
	input  wire                               clk,
	input  wire                               arst_n,
	// configuration port
	input  wire                               cfg_we,
	input  wire [ccht_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire [ccht_pkg::BYTES_W-1:0]       cfg_wdata,
	// request stream
	input  wire                               s_tvalid,
	output logic                              s_tready,
	input  wire [ccht_pkg::IN_W-1:0]          s_tdata,  // mode[2:0], cluster[12:3], file_open[13]
	// result stream
	output logic                              m_tvalid,
	input  wire                               m_tready,
	output logic [ccht_pkg::OUT_W-1:0]        m_tdata   // status[1:0], cluster_out[11:2],
	                                                    // chain_end[12], free_clusters[23:13],
	                                                    // free_bytes[49:24]
);

	ccht_pkg::cmd_t  cmd;
	ccht_pkg::stat_t stat;

	logic [ccht_pkg::STAT_W-1:0] status;
	logic [ccht_pkg::CL_W-1:0]   cluster_out;
	logic                        chain_end;
	logic [ccht_pkg::FC_W-1:0]   free_clusters;
	logic [ccht_pkg::FB_W-1:0]   free_bytes;

	ccht_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	ccht_dp #(
		.NUM_CLUSTERS (NUM_CLUSTERS)
	) u_dp (
		.clk               (clk),
		.arst_n            (arst_n),
		.cfg_we            (cfg_we),
		.cfg_index         (cfg_index),
		.cfg_wdata         (cfg_wdata),
		.in_mode           (s_tdata[2:0]),
		.in_cluster        (s_tdata[12:3]),
		.in_file_open      (s_tdata[13]),
		.out_ready         (m_tready),
		.out_valid         (m_tvalid),
		.out_status        (status),
		.out_cluster       (cluster_out),
		.out_chain_end     (chain_end),
		.out_free_clusters (free_clusters),
		.out_free_bytes    (free_bytes),
		.cmd               (cmd),
		.stat              (stat)
	);

	assign m_tdata = {6'd0, free_bytes, free_clusters, chain_end, cluster_out, status};

	// checks
	`CCHT_ASSERT_NOW(a_one_writer, $onehot0({cmd.sweep_step, cmd.walk_free, cmd.mark_end, cmd.link_wr}), "two RAM writers at once")
	`CCHT_ASSERT_NOW(a_one_reader, $onehot0({cmd.scan_step, cmd.rd_cluster, cmd.walk_adv}), "two RAM readers at once")
	`CCHT_ASSERT_NXT(a_one_request, s_tvalid && s_tready, !s_tready, "request taken while busy")
	`CCHT_ASSERT_IMP(a_emit_room, cmd.emit, !m_tvalid || m_tready, "result overwrites pending result")

endmodule

`default_nettype wire

/* tb/tb.sv */
// Testbench for cluster_chain_table: directed and random table operations, each result
// checked field by field against a model of the link table kept inside the bench.
// Depends on ccht_pkg and the cluster_chain_table RTL.

module tb;
	import ccht_pkg::*;

	localparam int NCL = 1024;
	localparam logic [ACT_W-1:0] LINK_FREE = ACT_W'(2 * NCL - 1);
	localparam logic [ACT_W-1:0] LINK_END  = ACT_W'(2 * NCL - 2);
	// modes the block answers with an empty result
	localparam logic [MODE_W-1:0] MODE_SPARE6 = 3'd6;
	localparam logic [MODE_W-1:0] MODE_SPARE7 = 3'd7;
	localparam logic [FB_W-1:0] FREE_BYTES_MAX = '1;
	localparam logic [FC_W-1:0] FREE_CLUSTERS_MAX = '1;

	// request fields, mode in the lowest bits
	typedef struct packed {
		logic              file_open;
		logic [CL_W-1:0]   cluster;
		logic [MODE_W-1:0] mode;
	} chain_req_t;

	// result fields, status in the lowest bits
	typedef struct packed {
		logic [FB_W-1:0]   free_bytes;
		logic [FC_W-1:0]   free_clusters;
		logic              chain_end;
		logic [CL_W-1:0]   cluster_out;
		logic [STAT_W-1:0] status;
	} chain_res_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [BYTES_W-1:0]   cfg_wdata = '0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [IN_W-1:0]      s_tdata = '0;
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [OUT_W-1:0]     m_tdata;

	// model of the table and its registers
	logic [ACT_W-1:0]   link_model [NCL];
	logic [ACT_W-1:0]   active_reg;
	logic [BYTES_W-1:0] bytes_reg;
	chain_res_t         pending_results [$];
	chain_res_t         got_res;
	chain_res_t         want_res;

	int sender_idle_pct = 0;
	int recv_stall_pct = 0;
	int error_count = 0;

	cluster_chain_table #(.NUM_CLUSTERS(NCL)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata)
	);

	initial forever #10 clk = ~clk;

	// --------------------------------------------------------------- table model

	function automatic int usable_count();
		return (active_reg < NCL) ? int'(active_reg) : NCL;
	endfunction

	function automatic int free_in_active();
		int cnt;
		cnt = 0;
		for (int i = 0; i < usable_count(); i++)
			if (link_model[i] == LINK_FREE) cnt++;
		return cnt;
	endfunction

	// lowest free active entry becomes END
	function automatic bit take_lowest_free(output logic [CL_W-1:0] got);
		got = '0;
		for (int i = 0; i < usable_count(); i++) begin
			if (link_model[i] == LINK_FREE) begin
				link_model[i] = LINK_END;
				got = CL_W'(i);
				return 1'b1;
			end
		end
		return 1'b0;
	endfunction

	function automatic chain_res_t predict_table_op(chain_req_t r);
		chain_res_t res;
		int n;
		int cur;
		int fc;
		longint prod;
		logic [ACT_W-1:0] nxt;
		logic [CL_W-1:0] got;
		res = '0;
		n = usable_count();
		case (r.mode)
			MODE_CLEAR: begin
				for (int i = 0; i < NCL; i++) link_model[i] = LINK_FREE;
			end
			MODE_ALLOC: begin
				if (take_lowest_free(got)) res.cluster_out = got;
				else res.status = ST_FULL;
			end
			MODE_EXTEND, MODE_FOLLOW: begin
				if (r.cluster >= n || link_model[r.cluster] == LINK_FREE) begin
					res.status = ST_BAD;
				end else if (link_model[r.cluster] == LINK_END) begin
					if (r.mode == MODE_FOLLOW) begin
						res.chain_end = 1'b1;
					end else if (take_lowest_free(got)) begin
						link_model[r.cluster] = ACT_W'(got);
						res.cluster_out = got;
					end else begin
						res.status = ST_FULL;
					end
				end else begin
					res.cluster_out = link_model[r.cluster][CL_W-1:0];
				end
			end
			MODE_FREE: begin
				if (r.file_open) begin
					res.status = ST_OPEN;
				end else if (r.cluster >= n) begin
					res.status = ST_BAD;
				end else begin
					// walk stops at END, a FREE link or a link past the active count
					cur = r.cluster;
					for (int steps = 0; steps < NCL; steps++) begin
						nxt = link_model[cur];
						if (nxt == LINK_FREE) break;
						link_model[cur] = LINK_FREE;
						if (nxt == LINK_END || nxt >= n) break;
						cur = nxt;
					end
				end
			end
			MODE_COUNT: begin
				fc = free_in_active();
				prod = longint'(fc) * longint'(bytes_reg);
				res.free_clusters = (fc > int'(FREE_CLUSTERS_MAX)) ? FREE_CLUSTERS_MAX : FC_W'(fc);
				res.free_bytes = (prod > longint'(FREE_BYTES_MAX)) ? FREE_BYTES_MAX : FB_W'(prod);
			end
			default: ;
		endcase
		return res;
	endfunction

	function automatic void reset_model();
		active_reg = ACT_W'(NCL);
		bytes_reg = BYTES_W'(512);
		for (int i = 0; i < NCL; i++) link_model[i] = LINK_FREE;
	endfunction

	// an entry in use, found from a random start; the start if none, any cluster if none are active
	function automatic logic [CL_W-1:0] busy_cluster();
		int n;
		int start;
		int idx;
		n = usable_count();
		if (n == 0) return CL_W'($urandom_range(NCL - 1));
		start = $urandom_range(n - 1);
		for (int k = 0; k < n; k++) begin
			idx = (start + k) % n;
			if (link_model[idx] != LINK_FREE) return CL_W'(idx);
		end
		return CL_W'(start);
	endfunction

	// --------------------------------------------------------------- drivers

	task automatic report_mismatch(string msg);
		error_count++;
		$display("MISMATCH at %0t: %s", $time, msg);
	endtask

	task automatic send_request(chain_req_t r);
		while ($urandom_range(99) < sender_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= IN_W'(r);
		do @(posedge clk); while (!s_tready);
		pending_results.push_back(predict_table_op(r));
	endtask

	task automatic send_op(logic [MODE_W-1:0] mode, int cluster, bit open);
		chain_req_t r;
		r.mode = mode;
		r.cluster = CL_W'(cluster);
		r.file_open = open;
		send_request(r);
	endtask

	// stop sending until every outstanding request is answered
	task automatic hold_until_answered();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (pending_results.size() != 0);
	endtask

	task automatic set_register(logic [CFG_IDX_W-1:0] idx, int value);
		hold_until_answered();
		repeat (8) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= BYTES_W'(value);
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_ACTIVE) active_reg = ACT_W'(value);
		else bytes_reg = BYTES_W'(value);
	endtask

	// receiver side
	always @(posedge clk) m_tready <= ($urandom_range(99) >= recv_stall_pct);

	// result checker
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			got_res = chain_res_t'(m_tdata[$bits(chain_res_t)-1:0]);
			if (pending_results.size() == 0) begin
				report_mismatch($sformatf("result with no request outstanding: %h", m_tdata));
			end else begin
				want_res = pending_results.pop_front();
				if (got_res.status !== want_res.status)
					report_mismatch($sformatf("status got %0d expected %0d",
						got_res.status, want_res.status));
				if (got_res.cluster_out !== want_res.cluster_out)
					report_mismatch($sformatf("cluster_out got %0d expected %0d",
						got_res.cluster_out, want_res.cluster_out));
				if (got_res.chain_end !== want_res.chain_end)
					report_mismatch($sformatf("chain_end got %0d expected %0d",
						got_res.chain_end, want_res.chain_end));
				if (got_res.free_clusters !== want_res.free_clusters)
					report_mismatch($sformatf("free_clusters got %0d expected %0d",
						got_res.free_clusters, want_res.free_clusters));
				if (got_res.free_bytes !== want_res.free_bytes)
					report_mismatch($sformatf("free_bytes got %0d expected %0d",
						got_res.free_bytes, want_res.free_bytes));
			end
		end
	end

	// --------------------------------------------------------------- tests

	// every operation on the reset table
	task automatic test_basic_operations();
		sender_idle_pct = 0;
		recv_stall_pct = 0;
		send_op(MODE_COUNT, 0, 1'b0);
		send_op(MODE_FOLLOW, 0, 1'b0);     // free entry
		send_op(MODE_ALLOC, 0, 1'b0);
		send_op(MODE_FOLLOW, 0, 1'b0);     // end of chain
		send_op(MODE_EXTEND, 0, 1'b0);     // links a new cluster
		send_op(MODE_EXTEND, 0, 1'b0);     // returns the existing link
		send_op(MODE_FREE, 0, 1'b1);       // refused, file open
		send_op(MODE_FREE, NCL - 1, 1'b0); // empty chain
		send_op(MODE_SPARE6, 0, 1'b0);
		send_op(MODE_SPARE7, NCL - 1, 1'b1);
		send_op(MODE_FREE, 0, 1'b0);
		send_op(MODE_COUNT, 0, 1'b0);
	endtask

	// full table, range checks, zero and oversized active counts, byte extremes
	task automatic test_table_limits();
		set_register(REG_ACTIVE, 2);
		set_register(REG_BYTES, 65535);
		send_op(MODE_ALLOC, 0, 1'b0);
		send_op(MODE_ALLOC, 0, 1'b0);
		send_op(MODE_ALLOC, 0, 1'b0);      // no free cluster
		send_op(MODE_EXTEND, 1, 1'b0);     // end entry, table full
		send_op(MODE_FOLLOW, 2, 1'b0);     // beyond active count
		send_op(MODE_FREE, NCL - 1, 1'b0); // beyond active count
		set_register(REG_ACTIVE, 0);
		send_op(MODE_COUNT, 0, 1'b0);
		send_op(MODE_EXTEND, 0, 1'b0);
		set_register(REG_ACTIVE, 2047);
		send_op(MODE_COUNT, 0, 1'b0);
		send_op(MODE_CLEAR, 0, 1'b0);
		set_register(REG_BYTES, 1);
		send_op(MODE_COUNT, 0, 1'b0);
	endtask

	// mostly chain work on entries in use, some stray clusters and noise
	task automatic run_random_ops(int num);
		chain_req_t r;
		int pick;
		int n;
		for (int i = 0; i < num; i++) begin
			n = usable_count();
			pick = $urandom_range(99);
			r.file_open = ($urandom_range(3) == 0);
			if (pick < 3) r.mode = MODE_W'($urandom_range(7));
			else if (pick < 5) r.mode = MODE_CLEAR;
			else if (pick < 23) r.mode = MODE_ALLOC;
			else if (pick < 50) r.mode = MODE_EXTEND;
			else if (pick < 70) r.mode = MODE_FOLLOW;
			else if (pick < 85) r.mode = MODE_FREE;
			else if (pick < 97) r.mode = MODE_COUNT;
			else r.mode = $urandom_range(1) ? MODE_SPARE6 : MODE_SPARE7;
			pick = $urandom_range(99);
			if (pick < 70) r.cluster = busy_cluster();
			else if (pick < 90 && n > 0) r.cluster = CL_W'($urandom_range(n - 1));
			else r.cluster = CL_W'($urandom_range(NCL - 1));
			if ($urandom_range(49) == 0) hold_until_answered();
			send_request(r);
		end
	endtask

	task automatic test_random_small_table();
		set_register(REG_ACTIVE, 32);
		set_register(REG_BYTES, $urandom_range(1, 65535));
		sender_idle_pct = 0;
		recv_stall_pct = 0;
		run_random_ops(140);
	endtask

	// shrinking the active count leaves links that point past it
	task automatic test_broken_chains();
		set_register(REG_ACTIVE, 20);
		sender_idle_pct = 86;
		recv_stall_pct = 0;
		run_random_ops(100);
	endtask

	task automatic test_stalled_receiver();
		set_register(REG_ACTIVE, 64);
		set_register(REG_BYTES, $urandom_range(1, 65535));
		sender_idle_pct = 0;
		recv_stall_pct = 86;
		run_random_ops(100);
	endtask

	task automatic test_full_size_table();
		set_register(REG_ACTIVE, NCL);
		set_register(REG_BYTES, 512);
		sender_idle_pct = 13;
		recv_stall_pct = 13;
		run_random_ops(60);
	endtask

	task automatic test_single_cluster();
		set_register(REG_ACTIVE, 1);
		set_register(REG_BYTES, $urandom_range(1, 65535));
		sender_idle_pct = 13;
		recv_stall_pct = 13;
		run_random_ops(40);
	endtask

	// short rounds at changing sizes, one of them past the table depth
	task automatic test_mixed_sizes();
		for (int round = 0; round < 6; round++) begin
			if (round == 3) set_register(REG_ACTIVE, $urandom_range(NCL + 1, 2047));
			else set_register(REG_ACTIVE, $urandom_range(2, 48));
			set_register(REG_BYTES, $urandom_range(1, 65535));
			sender_idle_pct = (round < 3) ? 0 : 13;
			recv_stall_pct = (round < 3) ? 0 : 13;
			run_random_ops(20);
		end
	endtask

	// --------------------------------------------------------------- sequence

	initial begin
		reset_model();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		test_basic_operations();
		test_table_limits();
		test_random_small_table();
		test_broken_chains();
		test_stalled_receiver();
		test_full_size_table();
		test_single_cluster();
		test_mixed_sizes();
		recv_stall_pct = 0;
		hold_until_answered();
		repeat (50) @(posedge clk);
		if (error_count == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

	// slowest correct run is roughly 580 full scans plus stalls, about 13M time units
	initial begin
		#60000000;
		$display("FAILURE");
		$finish;
	end

endmodule

/* sim.f */
+incdir+src
src/ccht_pkg.sv
src/ccht_ram.sv
src/ccht_ctrl.sv
src/ccht_dp.sv
src/cluster_chain_table.sv
tb/tb.sv
